>>> rtl/iupac_pattern_class_expander_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the IUPAC pattern class expander
// Shared forms for the concurrent checks at the end of the RTL module.
// ----------------------------------------------------------------------------
`ifndef IUPAC_PATTERN_CLASS_EXPANDER_MACROS_SVH
`define IUPAC_PATTERN_CLASS_EXPANDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPCE_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IPCE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ipce_pkg.sv
// ----------------------------------------------------------------------------
// IUPAC pattern class expander package
// Character codes, letter-set table and decode functions for the expander.
// ----------------------------------------------------------------------------
package ipce_pkg;

    // Widths of the stream fields.
    localparam int CHAR_W = 8;

    typedef logic [CHAR_W-1:0] t_char;

    // Letter sets are held right-justified in a fixed row of fifteen letters.
    localparam int SET_ROW_LEN = 15;
    localparam int IDX_W       = $clog2(SET_ROW_LEN);

    typedef logic [0:SET_ROW_LEN-1][CHAR_W-1:0] t_set_row;
    typedef logic [IDX_W-1:0]                   t_idx;
    typedef logic [3:0]                         t_set;

    // Decoded input character.
    typedef struct packed {
        logic amb;   // character is an ambiguity code
        t_set set;   // letter set to emit when amb is set
    } t_code;

    // Characters with a special meaning.
    localparam t_char CH_A     = "A";
    localparam t_char CH_B     = "B";
    localparam t_char CH_C     = "C";
    localparam t_char CH_D     = "D";
    localparam t_char CH_G     = "G";
    localparam t_char CH_H     = "H";
    localparam t_char CH_K     = "K";
    localparam t_char CH_M     = "M";
    localparam t_char CH_N     = "N";
    localparam t_char CH_R     = "R";
    localparam t_char CH_S     = "S";
    localparam t_char CH_T     = "T";
    localparam t_char CH_U     = "U";
    localparam t_char CH_V     = "V";
    localparam t_char CH_W     = "W";
    localparam t_char CH_Y     = "Y";
    localparam t_char CH_OPEN  = "[";
    localparam t_char CH_CLOSE = "]";

    // Letter set identifiers.
    localparam t_set SET_N = 4'd0;
    localparam t_set SET_B = 4'd1;
    localparam t_set SET_D = 4'd2;
    localparam t_set SET_H = 4'd3;
    localparam t_set SET_K = 4'd4;
    localparam t_set SET_M = 4'd5;
    localparam t_set SET_R = 4'd6;
    localparam t_set SET_S = 4'd7;
    localparam t_set SET_V = 4'd8;
    localparam t_set SET_W = 4'd9;
    localparam t_set SET_Y = 4'd10;

    // Letter set rows; shorter sets are zero-padded at the front.
    localparam t_set_row ROW_N = "ACGTRYMKWSBDHVN";
    localparam t_set_row ROW_B = "CGTB";
    localparam t_set_row ROW_D = "AGTD";
    localparam t_set_row ROW_H = "ACTH";
    localparam t_set_row ROW_K = "GTK";
    localparam t_set_row ROW_M = "ACM";
    localparam t_set_row ROW_R = "AGR";
    localparam t_set_row ROW_S = "CGS";
    localparam t_set_row ROW_V = "ACGV";
    localparam t_set_row ROW_W = "ATW";
    localparam t_set_row ROW_Y = "CTY";

    // Position of the final letter in every row.
    localparam t_idx IDX_LAST = t_idx'(SET_ROW_LEN - 1);

    // Row of letters for a set.
    function automatic t_set_row set_row(input t_set set);
        t_set_row row;
        unique case (set)
            SET_B:   row = ROW_B;
            SET_D:   row = ROW_D;
            SET_H:   row = ROW_H;
            SET_K:   row = ROW_K;
            SET_M:   row = ROW_M;
            SET_R:   row = ROW_R;
            SET_S:   row = ROW_S;
            SET_V:   row = ROW_V;
            SET_W:   row = ROW_W;
            SET_Y:   row = ROW_Y;
            default: row = ROW_N;
        endcase
        return row;
    endfunction

    // Row position of the first letter of a set.
    function automatic t_idx set_start(input t_set set);
        t_idx idx;
        unique case (set)
            SET_B, SET_D, SET_H, SET_V:        idx = t_idx'(SET_ROW_LEN - 4);
            SET_K, SET_M, SET_R, SET_S,
            SET_W, SET_Y:                      idx = t_idx'(SET_ROW_LEN - 3);
            default:                           idx = '0;
        endcase
        return idx;
    endfunction

    // Ambiguity code decode, with the complementary code taken in comp mode.
    function automatic t_code code_of(input t_char c, input logic comp);
        t_code code;
        code.amb = 1'b1;
        unique case (c)
            CH_B:    code.set = comp ? SET_V : SET_B;
            CH_D:    code.set = comp ? SET_H : SET_D;
            CH_H:    code.set = comp ? SET_D : SET_H;
            CH_K:    code.set = comp ? SET_M : SET_K;
            CH_M:    code.set = comp ? SET_K : SET_M;
            CH_N:    code.set = SET_N;
            CH_R:    code.set = comp ? SET_Y : SET_R;
            CH_S:    code.set = SET_S;
            CH_V:    code.set = comp ? SET_B : SET_V;
            CH_W:    code.set = SET_W;
            CH_Y:    code.set = comp ? SET_R : SET_Y;
            default: begin
                code.amb = 1'b0;
                code.set = SET_N;
            end
        endcase
        return code;
    endfunction

    // Single-letter mapping; U is treated as T, anything else passes.
    function automatic t_char single_of(input t_char c, input logic comp);
        t_char r;
        unique case (c)
            CH_A:       r = comp ? CH_T : CH_A;
            CH_C:       r = comp ? CH_G : CH_C;
            CH_G:       r = comp ? CH_C : CH_G;
            CH_T, CH_U: r = comp ? CH_A : CH_T;
            default:    r = c;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/iupac_pattern_class_expander.sv
// ----------------------------------------------------------------------------
// IUPAC pattern class expander
// Rewrites nucleotide pattern characters into regular-expression classes.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes one pattern character per transaction in
// s_axis_tdata, with s_axis_tlast marking the final character of a pattern.
// The master stream gives the expanded characters, one per transaction:
// m_axis_tlast marks the final character caused by one input, m_axis_tuser
// marks the final character of the whole pattern.
// A small sequencer walks a row of the letter-set table with one shared
// 4-bit index incrementer and compare, emitting one character a cycle while
// the output register has room. An input gives 1 to 17 output characters
// (17 for N outside a class), and the next input is taken in the cycle
// that emits the previous one's final character. After acceptance the
// sequencer state is registered, and the first character is then emitted
// into the output register, where a finished character waits while the next
// input is accepted; when the receiver stalls the sequencer holds its place.
// i_cfg_we writes complement mode from i_cfg_wdata; the user must do so only
// while the block is idle, which the block does not enforce. Synchronous reset
// clears the sequencer, output register, class flag and complement mode.
// ----------------------------------------------------------------------------
`include "iupac_pattern_class_expander_macros.svh"

module iupac_pattern_class_expander (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write: complement mode
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    // Slave stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] pattern_char
    input  logic                  s_axis_tlast,   // pattern_last
    // Master stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] out_char
    output logic                  m_axis_tlast,   // last_of_run
    output logic                  m_axis_tuser    // [0] pattern_end
);
    import ipce_pkg::*;

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_OPEN   = 3'd1;
    localparam logic [2:0] ST_BODY   = 3'd2;
    localparam logic [2:0] ST_CLOSE  = 3'd3;
    localparam logic [2:0] ST_SINGLE = 3'd4;

    logic [2:0] r_state, n_state;
    t_idx       r_idx, n_idx;
    t_set       r_set, n_set;
    t_char      r_char, n_char;
    logic       r_wrap, n_wrap;
    logic       r_last, n_last;
    logic       r_class_open, n_class_open;
    logic       r_comp, n_comp;
    logic       r_out_valid, n_out_valid;
    t_char      r_out_data, n_out_data;
    logic       r_out_tlast, n_out_tlast;
    logic       r_out_tuser, n_out_tuser;

    logic       w_emit;
    logic       w_final;
    logic       w_accept;
    t_char      w_emit_char;
    t_code      w_code;
    t_set_row   w_row;

    // Emission happens when there is work and room in the output register.
    assign w_emit = (r_state != ST_IDLE) && (!r_out_valid || m_axis_tready);

    // Current character and whether it ends the run.
    assign w_row = set_row(r_set);
    always_comb begin
        w_emit_char = r_char;
        w_final     = 1'b0;
        unique case (r_state)
            ST_OPEN: begin
                w_emit_char = CH_OPEN;
            end
            ST_BODY: begin
                w_emit_char = w_row[r_idx];
                w_final     = (r_idx == IDX_LAST) && !r_wrap;
            end
            ST_CLOSE: begin
                w_emit_char = CH_CLOSE;
                w_final     = 1'b1;
            end
            ST_SINGLE: begin
                w_final     = 1'b1;
            end
            default: begin
                w_emit_char = r_char;
            end
        endcase
    end

    // A new input is taken when idle or while the final character goes out.
    assign s_axis_tready = (r_state == ST_IDLE) || (w_emit && w_final);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_code        = code_of(s_axis_tdata, r_comp);

    // Sequencer and class flag next state.
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_set        = r_set;
        n_char       = r_char;
        n_wrap       = r_wrap;
        n_last       = r_last;
        n_class_open = r_class_open;
        n_comp       = i_cfg_we ? i_cfg_wdata : r_comp;

        if (w_emit) begin
            unique case (r_state)
                ST_OPEN: begin
                    n_state = ST_BODY;
                end
                ST_BODY: begin
                    if (r_idx == IDX_LAST) begin
                        n_state = r_wrap ? ST_CLOSE : ST_IDLE;
                    end else begin
                        n_idx = r_idx + t_idx'(1);
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end

        if (w_accept) begin
            n_set  = w_code.set;
            n_idx  = set_start(w_code.set);
            n_wrap = !r_class_open;
            n_last = s_axis_tlast;
            n_char = single_of(s_axis_tdata, r_comp);
            if (w_code.amb) begin
                n_state = r_class_open ? ST_BODY : ST_OPEN;
            end else begin
                n_state = ST_SINGLE;
                if (s_axis_tdata == CH_OPEN) begin
                    n_class_open = 1'b1;
                end else if (s_axis_tdata == CH_CLOSE) begin
                    n_class_open = 1'b0;
                end
            end
            if (s_axis_tlast) begin
                n_class_open = 1'b0;
            end
        end
    end

    // Output register next state.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_tlast = r_out_tlast;
        n_out_tuser = r_out_tuser;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_data  = w_emit_char;
            n_out_tlast = w_final;
            n_out_tuser = w_final && r_last;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_class_open <= 1'b0;
            r_comp       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_class_open <= n_class_open;
            r_comp       <= n_comp;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_set       <= n_set;
        r_char      <= n_char;
        r_wrap      <= n_wrap;
        r_last      <= n_last;
        r_out_data  <= n_out_data;
        r_out_tlast <= n_out_tlast;
        r_out_tuser <= n_out_tuser;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_tlast;
    assign m_axis_tuser  = r_out_tuser;

    // Checks on the sequencer and class flag.
    `IPCE_ASSERT_NOW(a_ready_only_at_run_end, i_clk, i_rst_n, s_axis_tready && (r_state != ST_IDLE), w_emit && w_final, "input taken while a run is still in progress")
    `IPCE_ASSERT_NOW(a_end_implies_last, i_clk, i_rst_n, r_out_valid && r_out_tuser, r_out_tlast, "pattern end flagged on a character that does not end its run")
    `IPCE_ASSERT_NEXT(a_open_sets_class, i_clk, i_rst_n, w_accept && (s_axis_tdata == CH_OPEN) && !s_axis_tlast, r_class_open, "opening bracket did not set the class flag")
    `IPCE_ASSERT_NEXT(a_last_clears_class, i_clk, i_rst_n, w_accept && s_axis_tlast, !r_class_open, "class flag survived the end of a pattern")

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the IUPAC pattern class expander
// Streams nucleotide pattern characters into the block with random gaps and
// back-pressure. It predicts every expanded character from its own model of
// the class flag and complement mode, then checks the output stream field by
// field.
// ----------------------------------------------------------------------------
module tb_top;
    import ipce_pkg::*;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 9;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 40;

    // One expected character of the expanded pattern.
    typedef struct packed {
        t_char out_char;
        logic  run_last;
        logic  pattern_end;
    } t_expansion_char;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_we      = 1'b0;
    logic       i_cfg_wdata   = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;    // [7:0] pattern_char
    logic       s_axis_tlast  = 1'b0;  // pattern_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [7:0] out_char
    logic       m_axis_tlast;          // last_of_run
    logic       m_axis_tuser;          // [0] pattern_end

    // Expected characters in output order, and the model's copy of the state.
    t_expansion_char pending_chars[$];
    bit              model_complement  = 1'b0;
    bit              model_class_open  = 1'b0;
    int unsigned     mismatch_count    = 0;
    int unsigned     items_sent        = 0;
    bit              idling_on         = 1'b1;
    int unsigned     hold_off_requests = 0;
    int unsigned     hold_off_served   = 0;
    int unsigned     hold_left         = 0;
    int unsigned     stall_left        = 0;
    int unsigned     quiet_cycles      = 0;
    string           iupac_letters     = "ACGTUBDHKMNRSVWY";

    iupac_pattern_class_expander DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock.
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Mostly short gaps, occasionally a long one.
    function automatic int unsigned pick_gap();
        int unsigned gap;
        if ($urandom_range(0, 9) == 0) begin
            gap = $urandom_range(20, 60);
        end else begin
            gap = $urandom_range(1, 3);
        end
        return gap;
    endfunction

    // Letter set of an ambiguity code, empty for any other character.
    // Complement mode takes the set of the complementary code.
    function automatic string class_letters(input t_char ch, input bit comp);
        string letters;
        case (ch)
            CH_N:    letters = "ACGTRYMKWSBDHVN";
            CH_B:    letters = comp ? "ACGV" : "CGTB";
            CH_D:    letters = comp ? "ACTH" : "AGTD";
            CH_H:    letters = comp ? "AGTD" : "ACTH";
            CH_K:    letters = comp ? "ACM" : "GTK";
            CH_M:    letters = comp ? "GTK" : "ACM";
            CH_R:    letters = comp ? "CTY" : "AGR";
            CH_S:    letters = "CGS";
            CH_V:    letters = comp ? "CGTB" : "ACGV";
            CH_W:    letters = "ATW";
            CH_Y:    letters = comp ? "AGR" : "CTY";
            default: letters = "";
        endcase
        return letters;
    endfunction

    // Plain bases map to one letter; U reads as T; anything else is copied.
    function automatic t_char base_letter(input t_char ch, input bit comp);
        t_char mapped;
        case (ch)
            CH_A:       mapped = comp ? CH_T : CH_A;
            CH_C:       mapped = comp ? CH_G : CH_C;
            CH_G:       mapped = comp ? CH_C : CH_G;
            CH_T, CH_U: mapped = comp ? CH_A : CH_T;
            default:    mapped = ch;
        endcase
        return mapped;
    endfunction

    // Work out the characters one accepted input gives and queue them.
    task automatic predict_expansion(input t_char ch, input bit last);
        string           letters;
        t_char           chars[$];
        t_expansion_char item;
        int              k;
        letters = class_letters(ch, model_complement);
        if (letters.len() != 0) begin
            if (!model_class_open) chars.push_back(CH_OPEN);
            for (k = 0; k < letters.len(); k++) chars.push_back(t_char'(letters[k]));
            if (!model_class_open) chars.push_back(CH_CLOSE);
        end else begin
            chars.push_back(base_letter(ch, model_complement));
            if (ch == CH_OPEN) begin
                model_class_open = 1'b1;
            end else if (ch == CH_CLOSE) begin
                model_class_open = 1'b0;
            end
        end
        // The end of a pattern always leaves the class.
        if (last) model_class_open = 1'b0;
        for (k = 0; k < chars.size(); k++) begin
            item.out_char    = chars[k];
            item.run_last    = (k == chars.size() - 1);
            item.pattern_end = item.run_last && last;
            pending_chars.push_back(item);
        end
    endtask

    // Offer one character and hold it until the transaction completes.
    task automatic send_char(input t_char ch, input bit last);
        int unsigned gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_expansion(ch, last);
        items_sent++;
    endtask

    // Send a string as one pattern, optionally marking its final character.
    task automatic send_string(input string text, input bit last_on_final);
        int k;
        for (k = 0; k < text.len(); k++) begin
            send_char(t_char'(text[k]), last_on_final && (k == text.len() - 1));
        end
    endtask

    // Stop offering input and wait until every expected character has come.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Write complement mode while the block is idle.
    task automatic set_complement(input bit mode);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we         <= 1'b0;
        model_complement = mode;
    endtask

    // A pattern of codes and bracket classes, with the odd stray byte or
    // unclosed class; the final character carries the pattern-end flag.
    task automatic send_random_pattern();
        t_char       chars[$];
        int unsigned elements;
        int unsigned roll;
        int          k;
        elements = $urandom_range(1, 8);
        repeat (elements) begin
            roll = $urandom_range(0, 9);
            if (roll < 2) begin
                chars.push_back(CH_OPEN);
                repeat ($urandom_range(1, 3)) begin
                    chars.push_back(t_char'(iupac_letters[$urandom_range(0, 15)]));
                end
                if (roll == 0 || $urandom_range(0, 5) != 0) chars.push_back(CH_CLOSE);
            end else if (roll == 9) begin
                chars.push_back(t_char'($urandom_range(0, 255)));
            end else begin
                chars.push_back(t_char'(iupac_letters[$urandom_range(0, 15)]));
            end
        end
        for (k = 0; k < chars.size(); k++) send_char(chars[k], k == chars.size() - 1);
    endtask

    // Every code as written, classes, stray and nested brackets, odd bytes.
    task automatic test_plain_codes();
        set_complement(1'b0);
        send_string("ACGTUBDHKMNRSVWY", 1'b0);
        send_string("[Ya[", 1'b0);
        send_char(CH_CLOSE, 1'b0);
        send_char(CH_CLOSE, 1'b0);
        // A pattern ending inside a class closes it for the next pattern.
        send_string("[R", 1'b1);
        send_char(CH_N, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
    endtask

    // Complementary codes, including Y expanding to the set of R.
    task automatic test_complement_codes();
        set_complement(1'b1);
        send_string("BDHKMRVYACGTU", 1'b0);
        send_string("[Y]", 1'b1);
    endtask

    // Random patterns, with the odd stray byte or unclosed class, in one mode.
    task automatic test_random_patterns(input bit mode, input int unsigned count);
        int unsigned target;
        set_complement(mode);
        target = items_sent + count;
        while (items_sent < target) begin
            idling_on = ($urandom_range(0, 4) != 0);
            send_random_pattern();
        end
        idling_on = 1'b1;
    endtask

    // Arbitrary bytes with arbitrary pattern-end flags.
    task automatic test_noise(input int unsigned count);
        repeat (count) begin
            send_char(t_char'($urandom_range(0, 255)), 1'b1 == $urandom_range(0, 1));
        end
    endtask

    // The receiver holds off for a long stretch while N characters keep coming.
    task automatic test_backpressure();
        idling_on = 1'b0;
        hold_off_requests <= hold_off_requests + 1;
        repeat (30) send_char(CH_N, $urandom_range(0, 7) == 0);
        idling_on = 1'b1;
    endtask

    // Receiver ready: random stalls, plus a long hold-off when requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_off_served != hold_off_requests) begin
            hold_off_served <= hold_off_requests;
            hold_left       <= HOLD_OFF_CYCLES;
            m_axis_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 3) == 0) begin
            stall_left    <= pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Report one field that differs from its prediction.
    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, name, expected, actual);
        end
    endtask

    // Compare every output transaction with the oldest prediction.
    always @(posedge i_clk) begin : output_check
        t_expansion_char want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_chars.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected output, expected none, actual %h %b %b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end else begin
                want = pending_chars.pop_front();
                check_field("out_char", want.out_char, m_axis_tdata);
                check_field("last_of_run", want.run_last, m_axis_tlast);
                check_field("pattern_end", want.pattern_end, m_axis_tuser);
            end
        end
    end

    // Watchdog: ends the run when no transaction happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_plain_codes();
        test_complement_codes();
        test_random_patterns(1'b0, 70);
        test_random_patterns(1'b1, 70);
        test_noise(40);
        test_backpressure();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
